[hw/rtl/mconv_pkg.sv]
package mconv_pkg;

	localparam int IDX_W  = 16;
	localparam int PIX_W  = 16;
	localparam int SUM_W  = 40;
	localparam int PROD_W = 2 * PIX_W;
	localparam int DIM_W  = 9;
	localparam int KDIM_W = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W  = DIM_W;
	localparam int CRD_W  = DIM_W + 2;
	localparam int BASE_W = 20;
	localparam int AREA_W = 2 * DIM_W;
	localparam int STEP_W = $clog2(IDX_W + 1);

	localparam logic [1:0] ACT_LOAD_KERNEL = 2'd0;
	localparam logic [1:0] ACT_LOAD_PIXEL  = 2'd1;
	localparam logic [1:0] ACT_COMPUTE     = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MASK_ENABLE   = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_TAP,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clear;
		logic valid;
	} mac_ctrl_t;

endpackage

[hw/rtl/mconv_if.sv]
interface mconv_item_if import mconv_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [1:0]               action;
	logic [IDX_W-1:0]         element_index;
	logic signed [PIX_W-1:0]  sample_value;
	logic                     mask_bit;

	modport source (output valid, action, element_index, sample_value, mask_bit,
		input ready);
	modport sink (input valid, action, element_index, sample_value, mask_bit,
		output ready);
endinterface

interface mconv_result_if import mconv_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [IDX_W-1:0]         pixel_index;
	logic signed [SUM_W-1:0]  pixel_sum;

	modport source (output valid, pixel_index, pixel_sum, input ready);
	modport sink (input valid, pixel_index, pixel_sum, output ready);
endinterface

[hw/rtl/mconv_ram.sv]
module mconv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hw/rtl/mconv_div.sv]
module mconv_div import mconv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [IDX_W-1:0]  dividend,
	input  logic [DIM_W-1:0]  divisor,
	output logic              done,
	output logic [IDX_W-1:0]  quotient,
	output logic [DIM_W-1:0]  remainder
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DIM_W-1:0]  rem_q;
	logic [IDX_W-1:0]  quo_q;
	logic [DIM_W:0]    trial;
	logic [DIM_W:0]    diff;
	logic              fits;

	assign trial = {rem_q, quo_q[IDX_W-1]};
	assign fits  = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(IDX_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
			quo_q <= {quo_q[IDX_W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

[hw/rtl/mconv_mac.sv]
module mconv_mac import mconv_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mac_ctrl_t               ctrl,
	input  logic signed [PIX_W-1:0] pixel,
	input  logic signed [PIX_W-1:0] weight,
	output logic signed [SUM_W-1:0] sum
);

	logic signed [PROD_W-1:0] prod_s2;
	logic signed [SUM_W-1:0]  acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_s2 <= '0;
			acc_q   <= '0;
		end else begin
			if (ctrl.valid) begin
				prod_s2 <= pixel * weight;
			end else begin
				prod_s2 <= '0;
			end
			if (ctrl.clear) begin
				acc_q <= '0;
			end else begin
				acc_q <= acc_q + SUM_W'(prod_s2);
			end
		end
	end

	assign sum = acc_q;

endmodule

[hw/rtl/masked_2d_convolution_top.sv]
// Zero-padded 2D convolution over an on-chip image store and kernel store.
// Load transactions write one kernel coefficient or one pixel with its mask bit
// and are taken one per cycle while no compute transaction is in progress. A
// compute transaction names one output pixel by raster index and runs through
// these steps before the next transaction is accepted: the radix-2 divider
// splits the index into column and row, the single multiply-accumulate unit
// takes one kernel tap per cycle, its pipeline drains, and the result is handed
// to the output register; that last step stretches while an earlier result
// still waits there. A masked or out-of-range pixel skips the tap loop and gives
// a sum of zero. The result register lets the next transaction be accepted while
// a result waits. Stores hold nothing meaningful until written, and no clearing
// pass runs.
module masked_2d_convolution_top import mconv_pkg::*; #(
	parameter int MAX_IMAGE_WIDTH   = 256,
	parameter int MAX_IMAGE_HEIGHT  = 256,
	parameter int MAX_KERNEL_WIDTH  = 15,
	parameter int MAX_KERNEL_HEIGHT = 15
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	mconv_item_if.sink           item,
	mconv_result_if.source       result
);

	localparam int IMG_DEPTH = MAX_IMAGE_WIDTH * MAX_IMAGE_HEIGHT;
	localparam int KRN_DEPTH = MAX_KERNEL_WIDTH * MAX_KERNEL_HEIGHT;
	localparam int IAW = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
	localparam int KAW = (KRN_DEPTH > 1) ? $clog2(KRN_DEPTH) : 1;

	state_t state_q, state_d;

	logic [DIM_W-1:0]  image_width_q, image_height_q;
	logic [KDIM_W-1:0] kernel_width_q, kernel_height_q;
	logic              mask_enable_q;

	logic [DIM_W-1:0]  iw, ih;
	logic [KDIM_W-1:0] kw, kh, cx, cy;

	logic [IDX_W-1:0]        idx_q;
	logic [AREA_W-1:0]       area_q;
	logic [KDIM_W+DIM_W-1:0] cyiw_q;
	logic signed [CRD_W-1:0] sc_start_q, sc_q, sr_q;
	logic signed [BASE_W-1:0] base_q;
	logic [KAW-1:0]          kaddr_q;
	logic [KDIM_W-1:0]       kc_q, kr_q;
	logic                    valid_s1;
	logic                    drain_q;

	logic                    out_valid_q;
	logic [IDX_W-1:0]        out_index_q;
	logic signed [SUM_W-1:0] out_sum_q;

	logic accept, is_compute, pass, last_row_tap, last_tap, tap_ok, sc_ok, sr_ok, out_load;
	logic div_done;
	logic [IDX_W-1:0] div_quo;
	logic [DIM_W-1:0] div_rem;
	mac_ctrl_t mac_ctrl;
	logic signed [SUM_W-1:0] mac_sum;

	logic              img_we, krn_we;
	logic [IAW-1:0]    img_raddr;
	logic [PIX_W:0]    img_rdata;
	logic [PIX_W-1:0]  krn_rdata;
	logic signed [BASE_W-1:0] tap_addr;

	always_comb begin
		if (image_width_q == '0) begin
			iw = DIM_W'(1);
		end else if (32'(image_width_q) > MAX_IMAGE_WIDTH) begin
			iw = DIM_W'(MAX_IMAGE_WIDTH);
		end else begin
			iw = image_width_q;
		end
		if (image_height_q == '0) begin
			ih = DIM_W'(1);
		end else if (32'(image_height_q) > MAX_IMAGE_HEIGHT) begin
			ih = DIM_W'(MAX_IMAGE_HEIGHT);
		end else begin
			ih = image_height_q;
		end
		if (kernel_width_q == '0) begin
			kw = KDIM_W'(1);
		end else if (32'(kernel_width_q) > MAX_KERNEL_WIDTH) begin
			kw = KDIM_W'(MAX_KERNEL_WIDTH);
		end else begin
			kw = kernel_width_q;
		end
		if (kernel_height_q == '0) begin
			kh = KDIM_W'(1);
		end else if (32'(kernel_height_q) > MAX_KERNEL_HEIGHT) begin
			kh = KDIM_W'(MAX_KERNEL_HEIGHT);
		end else begin
			kh = kernel_height_q;
		end
		cx = kw >> 1;
		cy = kh >> 1;
	end

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign is_compute = (item.action == ACT_COMPUTE);

	assign pass = (AREA_W'(idx_q) < area_q) && !(mask_enable_q && !img_rdata[PIX_W]);
	assign last_row_tap = (kc_q == kw - 1'b1);
	assign last_tap     = last_row_tap && (kr_q == kh - 1'b1);
	assign sc_ok  = !sc_q[CRD_W-1] && (sc_q[CRD_W-2:0] < (CRD_W-1)'(iw));
	assign sr_ok  = !sr_q[CRD_W-1] && (sr_q[CRD_W-2:0] < (CRD_W-1)'(ih));
	assign tap_ok = sc_ok && sr_ok;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || result.ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_compute) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = pass ? ST_TAP : ST_DONE;
				end
			end
			ST_TAP: begin
				if (last_tap) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_q) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			image_width_q   <= DIM_W'(256);
			image_height_q  <= DIM_W'(256);
			kernel_width_q  <= KDIM_W'(3);
			kernel_height_q <= KDIM_W'(3);
			mask_enable_q   <= 1'b0;
			valid_s1        <= 1'b0;
			drain_q         <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= (state_q == ST_TAP) && tap_ok;
			drain_q  <= (state_q == ST_DRAIN) && !drain_q;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_IMAGE_WIDTH:   image_width_q   <= cfg_wdata;
					CFG_IMAGE_HEIGHT:  image_height_q  <= cfg_wdata;
					CFG_KERNEL_WIDTH:  kernel_width_q  <= cfg_wdata[KDIM_W-1:0];
					CFG_KERNEL_HEIGHT: kernel_height_q <= cfg_wdata[KDIM_W-1:0];
					CFG_MASK_ENABLE:   mask_enable_q   <= cfg_wdata[0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_compute) begin
					idx_q  <= item.element_index;
					area_q <= iw * ih;
					cyiw_q <= cy * iw;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					sc_start_q <= $signed(CRD_W'(div_rem)) - $signed(CRD_W'(cx));
					sc_q       <= $signed(CRD_W'(div_rem)) - $signed(CRD_W'(cx));
					sr_q       <= $signed(CRD_W'(div_quo[DIM_W-1:0])) - $signed(CRD_W'(cy));
					base_q     <= $signed(BASE_W'(idx_q)) - $signed(BASE_W'(div_rem))
						- $signed(BASE_W'(cyiw_q));
					kaddr_q    <= '0;
					kc_q       <= '0;
					kr_q       <= '0;
				end
			end
			ST_TAP: begin
				kaddr_q <= kaddr_q + 1'b1;
				if (last_row_tap) begin
					kc_q   <= '0;
					kr_q   <= kr_q + 1'b1;
					sc_q   <= sc_start_q;
					sr_q   <= sr_q + 1'b1;
					base_q <= base_q + $signed(BASE_W'(iw));
				end else begin
					kc_q <= kc_q + 1'b1;
					sc_q <= sc_q + 1'b1;
				end
			end
			ST_DRAIN, ST_DONE: ;
			default: ;
		endcase
		if (out_load) begin
			out_index_q <= idx_q;
			out_sum_q   <= mac_sum;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.pixel_index = out_index_q;
	assign result.pixel_sum   = out_sum_q;

	mconv_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept && is_compute),
		.dividend  (item.element_index),
		.divisor   (iw),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign tap_addr  = base_q + BASE_W'(sc_q);
	assign img_raddr = (state_q == ST_TAP) ? IAW'(tap_addr) : IAW'(idx_q);
	assign img_we = accept && (item.action == ACT_LOAD_PIXEL)
		&& (32'(item.element_index) < IMG_DEPTH);
	assign krn_we = accept && (item.action == ACT_LOAD_KERNEL)
		&& (32'(item.element_index) < KRN_DEPTH);

	mconv_ram #(
		.WIDTH (PIX_W + 1),
		.DEPTH (IMG_DEPTH)
	) u_img_ram (
		.clk   (clk),
		.we    (img_we),
		.waddr (IAW'(item.element_index)),
		.wdata ({item.mask_bit, item.sample_value}),
		.raddr (img_raddr),
		.rdata (img_rdata)
	);

	mconv_ram #(
		.WIDTH (PIX_W),
		.DEPTH (KRN_DEPTH)
	) u_krn_ram (
		.clk   (clk),
		.we    (krn_we),
		.waddr (KAW'(item.element_index)),
		.wdata (item.sample_value),
		.raddr (kaddr_q),
		.rdata (krn_rdata)
	);

	assign mac_ctrl.clear = (state_q == ST_DIV) && div_done;
	assign mac_ctrl.valid = valid_s1;

	mconv_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.pixel  ($signed(img_rdata[PIX_W-1:0])),
		.weight ($signed(krn_rdata)),
		.sum    (mac_sum)
	);

endmodule
